@@ rtl/core/byte_ring_buffer_burst_top_assert.svh @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - assertion macros
// Shared assertion forms used by the top level, sampled on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_BURST_TOP_ASSERT_SVH
`define BYTE_RING_BUFFER_BURST_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BRBB_CHECK_NOW(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BRBB_CHECK_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ rtl/core/brbb_pkg.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - package
// Widths, operation codes and the command/status bundles between units.
// ---------------------------------------------------------------------------
package brbb_pkg;

  localparam int STORE_DEPTH    = 4096;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int RING_W         = ADDR_W + 1;
  localparam int LEN_W          = 12;
  localparam int MODE_W         = 3;
  localparam int DATA_W         = 64;
  localparam int BYTES_PER_ITEM = 8;
  localparam int CNT_W          = $clog2(BYTES_PER_ITEM + 1);
  localparam int IDX_W          = $clog2(BYTES_PER_ITEM);
  localparam int RING_MIN       = 2;

  localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE_KEEP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SKIP_WRITE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SKIP_READ  = 3'd5;

  typedef struct packed {
    logic take;      // latch the accepted item
    logic clr_step;  // write zero at the sweep address, advance it
    logic load_wr;   // start a byte burst at the write pointer
    logic load_rd;   // start a byte burst at the read pointer
    logic wr_step;   // store one byte, advance
    logic rd_step;   // fetch one byte, advance
    logic commit;    // update pointers and load the result register
  } cmd_t;

  typedef struct packed {
    logic ok;          // operation will be carried out
    logic nonzero;     // length is not zero
    logic wr_data;     // write or write without advance
    logic rd_data;     // read or peek
    logic burst_last;  // current byte is the last of the burst
    logic clr_last;    // sweep is at the last store entry
    logic out_free;    // result register can take a new result
  } stat_t;

endpackage

@@ rtl/core/brbb_if.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - channel interfaces
// Valid/ready channels for the operation items and the result items.
// ---------------------------------------------------------------------------
interface brbb_req_if;
  logic                               valid;
  logic                               ready;
  logic [brbb_pkg::MODE_W-1:0]        mode;
  logic [brbb_pkg::LEN_W-1:0]         length;
  logic [brbb_pkg::DATA_W-1:0]        data_bytes;

  modport source (output valid, mode, length, data_bytes, input ready);
  modport sink   (input valid, mode, length, data_bytes, output ready);
endinterface

interface brbb_res_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic [brbb_pkg::DATA_W-1:0]        read_bytes;
  logic [brbb_pkg::LEN_W-1:0]         free_space;
  logic [brbb_pkg::LEN_W-1:0]         available;

  modport source (output valid, ok, read_bytes, free_space, available, input ready);
  modport sink   (input valid, ok, read_bytes, free_space, available, output ready);
endinterface

@@ rtl/core/brbb_ram.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - generic RAM
// Single port, read first (old data on a write), registered read data.
// ---------------------------------------------------------------------------
module brbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/brbb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - controller
// Sequences the clearing sweep, the decision, the byte bursts and the commit.
// ---------------------------------------------------------------------------
module brbb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  brbb_pkg::stat_t stat,
  output brbb_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.ok && stat.nonzero && stat.wr_data) begin
          cmd.load_wr = 1'b1;
          state_next  = ST_WRITE;
        end else if (stat.ok && stat.nonzero && stat.rd_data) begin
          cmd.load_rd = 1'b1;
          state_next  = ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        if (stat.burst_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_step = 1'b1;
        if (stat.burst_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/brbb_dp.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - datapath
// Pointers, fill level, byte store, burst registers and the result register.
// ---------------------------------------------------------------------------
module brbb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [brbb_pkg::RING_W-1:0]   cfg_write_data,
  input  logic [brbb_pkg::MODE_W-1:0]   req_mode,
  input  logic [brbb_pkg::LEN_W-1:0]    req_length,
  input  logic [brbb_pkg::DATA_W-1:0]   req_data,
  input  brbb_pkg::cmd_t                cmd,
  output brbb_pkg::stat_t               stat,
  brbb_res_if.source                    result
);

  logic [brbb_pkg::RING_W-1:0] ring_size;
  logic [brbb_pkg::ADDR_W-1:0] wr_ptr;
  logic [brbb_pkg::ADDR_W-1:0] rd_ptr;
  logic [brbb_pkg::LEN_W-1:0]  used;
  logic [brbb_pkg::LEN_W-1:0]  space;

  logic [brbb_pkg::MODE_W-1:0] mode;
  logic [brbb_pkg::LEN_W-1:0]  len;
  logic [brbb_pkg::DATA_W-1:0] data_sh;
  logic [brbb_pkg::DATA_W-1:0] rd_acc;
  logic [brbb_pkg::CNT_W-1:0]  count;
  logic [brbb_pkg::ADDR_W-1:0] addr;
  logic                        cap_valid;
  logic [brbb_pkg::IDX_W-1:0]  cap_idx;

  logic [7:0] ram_rdata;
  logic       ram_we;
  logic [7:0] ram_wdata;

  logic too_long, wr_side, rd_side, op_ok, adv_w, adv_r;
  logic [brbb_pkg::RING_W-1:0] wr_sum, rd_sum, addr_inc, ring_new;
  logic [brbb_pkg::ADDR_W-1:0] wr_ptr_adv, rd_ptr_adv, addr_adv;
  logic [brbb_pkg::LEN_W-1:0]  used_new, space_new;

  // Decision on the latched item
  always_comb begin
    too_long = (mode == brbb_pkg::MODE_WRITE || mode == brbb_pkg::MODE_READ ||
                mode == brbb_pkg::MODE_PEEK  || mode == brbb_pkg::MODE_WRITE_KEEP) &&
               (len > brbb_pkg::LEN_W'(brbb_pkg::BYTES_PER_ITEM));
    wr_side  = (mode == brbb_pkg::MODE_WRITE || mode == brbb_pkg::MODE_WRITE_KEEP ||
                mode == brbb_pkg::MODE_SKIP_WRITE);
    rd_side  = (mode == brbb_pkg::MODE_READ || mode == brbb_pkg::MODE_PEEK ||
                mode == brbb_pkg::MODE_SKIP_READ);
    op_ok    = !too_long && ((wr_side && len <= space) || (rd_side && len <= used));
    adv_w    = op_ok && (mode == brbb_pkg::MODE_WRITE || mode == brbb_pkg::MODE_SKIP_WRITE);
    adv_r    = op_ok && (mode == brbb_pkg::MODE_READ || mode == brbb_pkg::MODE_SKIP_READ);
  end

  // Pointer advance: distance stays below the ring size, one subtract wraps it
  always_comb begin
    wr_sum     = brbb_pkg::RING_W'(wr_ptr) + brbb_pkg::RING_W'(len);
    rd_sum     = brbb_pkg::RING_W'(rd_ptr) + brbb_pkg::RING_W'(len);
    wr_ptr_adv = (wr_sum >= ring_size) ? brbb_pkg::ADDR_W'(wr_sum - ring_size)
                                       : wr_sum[brbb_pkg::ADDR_W-1:0];
    rd_ptr_adv = (rd_sum >= ring_size) ? brbb_pkg::ADDR_W'(rd_sum - ring_size)
                                       : rd_sum[brbb_pkg::ADDR_W-1:0];
    addr_inc   = brbb_pkg::RING_W'(addr) + brbb_pkg::RING_W'(1);
    addr_adv   = (addr_inc == ring_size) ? '0 : addr_inc[brbb_pkg::ADDR_W-1:0];
  end

  always_comb begin
    if (adv_w) begin
      used_new  = used + len;
      space_new = space - len;
    end else if (adv_r) begin
      used_new  = used - len;
      space_new = space + len;
    end else begin
      used_new  = used;
      space_new = space;
    end
  end

  always_comb begin
    if (cfg_write_data < brbb_pkg::RING_W'(brbb_pkg::RING_MIN)) begin
      ring_new = brbb_pkg::RING_W'(brbb_pkg::RING_MIN);
    end else if (cfg_write_data > brbb_pkg::RING_W'(brbb_pkg::STORE_DEPTH)) begin
      ring_new = brbb_pkg::RING_W'(brbb_pkg::STORE_DEPTH);
    end else begin
      ring_new = cfg_write_data;
    end
  end

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= brbb_pkg::RING_W'(brbb_pkg::STORE_DEPTH);
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      used      <= '0;
      space     <= brbb_pkg::LEN_W'(brbb_pkg::STORE_DEPTH - 1);
    end else if (cfg_write_en) begin
      ring_size <= ring_new;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      used      <= '0;
      space     <= brbb_pkg::LEN_W'(ring_new - brbb_pkg::RING_W'(1));
    end else if (cmd.commit) begin
      if (adv_w) begin
        wr_ptr <= wr_ptr_adv;
      end
      if (adv_r) begin
        rd_ptr <= rd_ptr_adv;
      end
      used  <= used_new;
      space <= space_new;
    end
  end

  // Burst control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      cap_valid <= 1'b0;
    end else begin
      cap_valid <= cmd.rd_step;
      if (cmd.clr_step) begin
        addr <= addr + brbb_pkg::ADDR_W'(1);
      end else if (cmd.load_wr) begin
        addr <= wr_ptr;
      end else if (cmd.load_rd) begin
        addr <= rd_ptr;
      end else if (cmd.wr_step || cmd.rd_step) begin
        addr <= addr_adv;
      end
    end
  end

  // Item payload and burst data
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode    <= req_mode;
      len     <= req_length;
      data_sh <= req_data;
      rd_acc  <= '0;
      count   <= '0;
    end else begin
      if (cmd.wr_step) begin
        data_sh <= data_sh >> 8;
      end
      if (cmd.wr_step || cmd.rd_step) begin
        count <= count + brbb_pkg::CNT_W'(1);
      end
      if (cap_valid) begin
        rd_acc[cap_idx*8 +: 8] <= ram_rdata;
      end
    end
    cap_idx <= count[brbb_pkg::IDX_W-1:0];
  end

  assign ram_we    = cmd.clr_step || cmd.wr_step;
  assign ram_wdata = cmd.clr_step ? 8'h00 : data_sh[7:0];

  brbb_ram #(
    .WIDTH (8),
    .DEPTH (brbb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.ok         <= op_ok;
      result.read_bytes <= op_ok ? rd_acc : '0;
      result.free_space <= space_new;
      result.available  <= used_new;
    end
  end

  always_comb begin
    stat.ok         = op_ok;
    stat.nonzero    = (len != '0);
    stat.wr_data    = (mode == brbb_pkg::MODE_WRITE || mode == brbb_pkg::MODE_WRITE_KEEP);
    stat.rd_data    = (mode == brbb_pkg::MODE_READ || mode == brbb_pkg::MODE_PEEK);
    stat.burst_last = (brbb_pkg::LEN_W'(count) + brbb_pkg::LEN_W'(1) == len);
    stat.clr_last   = (addr == '1);
    stat.out_free   = !result.valid || result.ready;
  end

endmodule

@@ rtl/core/byte_ring_buffer_burst_top.sv @@
// ---------------------------------------------------------------------------
// Byte ring buffer burst - top level
// Circular byte FIFO with all-or-nothing burst writes, reads, peeks and skips.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   request   in         valid/ready    mode, length, data_bytes
//   result    out        valid/ready    ok, read_bytes, free_space, available
//   cfg       in         cfg_write_en   cfg_write_data (ring size, clamped)
//
// Each item is taken, decided, burst byte by byte if it is an accepted write,
// read or peek of nonzero length, and committed; the single-port byte store
// moves one byte per cycle. After reset a sweep zeroes the store, one entry
// per cycle, with request.ready low. Configuration writes are taken during
// the sweep.
// The result register lets the next item in while a result waits; a stalled
// result only holds the finishing item.
//
module byte_ring_buffer_burst_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [brbb_pkg::RING_W-1:0] cfg_write_data,
  brbb_req_if.sink                    request,
  brbb_res_if.source                  result
);

`include "byte_ring_buffer_burst_top_assert.svh"

  brbb_pkg::cmd_t  cmd;
  brbb_pkg::stat_t stat;
  logic            ready;

  // Controller: sweep, decide, run the byte burst, commit
  brbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  assign request.ready = ready;

  // Datapath: pointers, fill level, byte store and result register
  brbb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_mode       (request.mode),
    .req_length     (request.length),
    .req_data       (request.data_bytes),
    .cmd            (cmd),
    .stat           (stat),
    .result         (result)
  );

  // A commit always leaves a result for the output side
  `BRBB_CHECK_NEXT(a_commit_gives_result, cmd.commit, result.valid, "commit lost its result")

  // Free space and fill level together never exceed the store depth less one
  `BRBB_CHECK_NOW(a_level_sum, result.valid, (13'(result.free_space) + 13'(result.available)) <= 13'(brbb_pkg::STORE_DEPTH - 1), "free space plus available too large")

  // A refused operation returns no data
  `BRBB_CHECK_NOW(a_refused_no_data, result.valid && !result.ok, result.read_bytes == '0, "refused operation returned data")

  // No store traffic while a new item may be taken
  `BRBB_CHECK_NOW(a_idle_no_traffic, request.ready, !(cmd.wr_step || cmd.rd_step || cmd.clr_step), "store busy while ready")

endmodule
